// File: sv/hamming_disparity_search_unit_macros.svh
// assertion macros for the hamming disparity search unit
// each macro expands to a concurrent assertion in simulation and to nothing in synthesis
`ifndef HAMMING_DISPARITY_SEARCH_UNIT_MACROS_SVH
`define HAMMING_DISPARITY_SEARCH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define HDSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hdsu assertion failed");
`define HDSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hdsu assertion failed");
`else
`define HDSU_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define HDSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: sv/hdsu_pkg.sv
// shared types, widths and helpers for the hamming disparity search unit
// no dependencies
`timescale 1ns / 1ps

package hdsu_pkg;

    localparam int DESC_W  = 64;
    localparam int DIFF_W  = 7;
    localparam int LIMIT_W = 9;
    localparam int MATCH_W = 8;
    localparam int LEV_W   = 7;
    localparam int SCALE_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;
    localparam int OUT_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd1;

    typedef struct packed {
        logic               valid;
        logic [DESC_W-1:0]  ldesc;
        logic [DESC_W-1:0]  emask;
        logic [LIMIT_W-1:0] limit;
        logic [DIFF_W-1:0]  min_diff;
        logic [MATCH_W-1:0] match;
    } hdsu_tok_t;

    function automatic logic [DIFF_W-1:0] popcount(input logic [DESC_W-1:0] v);
        logic [DIFF_W-1:0] n;
        n = '0;
        for (int b = 0; b < DESC_W; b++) begin
            n = n + DIFF_W'(v[b]);
        end
        return n;
    endfunction

endpackage

// File: sv/hdsu_cell.sv
// one window cell: holds a right descriptor and scores the passing search request
// depends on hdsu_pkg
`timescale 1ns / 1ps

module hdsu_cell
    import hdsu_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic [DESC_W-1:0] desc_in,
    output logic [DESC_W-1:0] desc_out,
    input  hdsu_tok_t         tok_in,
    output hdsu_tok_t         tok_out
);

    logic [DESC_W-1:0] desc_reg;
    hdsu_tok_t         tok_reg;
    hdsu_tok_t         tok_next;
    logic [DIFF_W-1:0] diff;
    logic              hit;

    always_comb begin
        diff = popcount((tok_in.ldesc ^ desc_reg) & tok_in.emask);
        hit  = (LIMIT_W'(IDX) < tok_in.limit) && (diff < tok_in.min_diff);
        tok_next = tok_in;
        if (hit) begin
            tok_next.min_diff = diff;
            tok_next.match    = MATCH_W'(IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            desc_reg <= desc_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    assign desc_out = desc_reg;
    assign tok_out  = tok_reg;

endmodule

// File: sv/hamming_disparity_search_unit.sv
// top level of the hamming disparity search unit: config registers, window control, result stage
// depends on hdsu_pkg, hdsu_cell and hamming_disparity_search_unit_macros.svh
// channel  | dir | width | contents
// s_axis   | in  | 192+2 | left desc, left mask, right desc; tuser first_in_row, edge flag
// m_axis   | out | 8     | disparity_out
// cfg      | in  | 2+8   | register index, write data
// a request is registered at the input, then walks the cell chain one cell per cycle,
// then moves into the pending slot and from there into the output register
// the next request is taken once the previous result sits in the output register
// a stalled output holds its result; the pending slot waits for it to drain
// reset (aresetn low, synchronous) restores the registers and empties the window
`timescale 1ns / 1ps
`include "hamming_disparity_search_unit_macros.svh"

module hamming_disparity_search_unit
    import hdsu_pkg::*;
#(
    parameter int DESC_BITS = 64,
    parameter int MAX_DISP  = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // left_desc [63:0], left_mask [127:64], right_desc [191:128]
    input  logic [191:0]         s_tdata,
    // first_in_row [0], left_edge_area [1]
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // disparity_out [7:0]
    output logic [OUT_W-1:0]     m_tdata,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_wdata
);

    localparam int VC_W = $clog2(MAX_DISP + 1);
    localparam logic [DESC_W-1:0] DescMask = {DESC_W{1'b1}} >> (DESC_W - DESC_BITS);
    localparam logic [DIFF_W-1:0] WeakMax  = DIFF_W'(DESC_BITS / 16);

    logic [LEV_W-1:0]   levels_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [VC_W-1:0]    vc_reg, vc_next, vc_base;
    logic               busy_reg, busy_next;
    hdsu_tok_t          tok_reg, tok_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [MATCH_W-1:0] pend_match_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]   m_tdata_reg;

    logic [DESC_W-1:0]  left_desc, left_mask, right_desc;
    logic               first_in_row, left_edge_area;
    logic               s_accept, pend_move, weak_mask;
    logic [LIMIT_W-1:0] lev_c, vc_ext, limit;
    logic [2*SCALE_W-1:0] prod;

    hdsu_tok_t          tok_chain [0:MAX_DISP];
    logic [DESC_W-1:0]  desc_chain [0:MAX_DISP];
    logic [MAX_DISP:0]  chain_vld;

    assign left_desc      = s_tdata[63:0];
    assign left_mask      = s_tdata[127:64];
    assign right_desc     = s_tdata[191:128];
    assign first_in_row   = s_tuser[0];
    assign left_edge_area = s_tuser[1];

    assign s_tready  = !busy_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign pend_move = pend_valid_reg && (!m_tvalid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LEV_W'(64);
            scale_reg  <= SCALE_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LEVELS: levels_reg <= cfg_wdata[LEV_W-1:0];
                REG_SCALE:  scale_reg  <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        vc_base = first_in_row ? '0 : vc_reg;
        vc_next = vc_reg;
        if (s_accept) begin
            vc_next = (vc_base < VC_W'(MAX_DISP)) ? vc_base + VC_W'(1) : vc_base;
        end
        lev_c = (LIMIT_W'(levels_reg) > LIMIT_W'(MAX_DISP)) ? LIMIT_W'(MAX_DISP)
                                                           : LIMIT_W'(levels_reg);
        vc_ext = LIMIT_W'(vc_next);
        weak_mask = left_edge_area && (popcount(left_mask & DescMask) <= WeakMax);
        limit  = weak_mask ? '0 : ((lev_c < vc_ext) ? lev_c : vc_ext);

        tok_next          = '0;
        tok_next.valid    = s_accept;
        tok_next.ldesc    = left_desc;
        tok_next.emask    = left_edge_area ? (left_mask & DescMask) : DescMask;
        tok_next.limit    = limit;
        tok_next.min_diff = DIFF_W'(DESC_BITS);
        tok_next.match    = '0;

        busy_next = busy_reg;
        if (s_accept) begin
            busy_next = 1'b1;
        end else if (pend_move) begin
            busy_next = 1'b0;
        end

        pend_valid_next = pend_valid_reg;
        if (tok_chain[MAX_DISP].valid) begin
            pend_valid_next = 1'b1;
        end else if (pend_move) begin
            pend_valid_next = 1'b0;
        end

        m_tvalid_next = m_tvalid_reg;
        if (pend_move) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        prod = SCALE_W'(pend_match_reg) * scale_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg         <= '0;
            busy_reg       <= 1'b0;
            tok_reg.valid  <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            vc_reg         <= vc_next;
            busy_reg       <= busy_next;
            tok_reg        <= tok_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tok_chain[MAX_DISP].valid) begin
            pend_match_reg <= tok_chain[MAX_DISP].match;
        end
        if (pend_move) begin
            m_tdata_reg <= prod[OUT_W-1:0];
        end
    end

    assign tok_chain[0]  = tok_reg;
    assign desc_chain[0] = right_desc;

    for (genvar i = 0; i < MAX_DISP; i++) begin : g_cell
        hdsu_cell #(
            .IDX(i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .shift_en(s_accept),
            .desc_in (desc_chain[i]),
            .desc_out(desc_chain[i+1]),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1])
        );
    end

    always_comb begin
        for (int k = 0; k <= MAX_DISP; k++) begin
            chain_vld[k] = tok_chain[k].valid;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `HDSU_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_tready)
    `HDSU_ASSERT_SAME(a_one_request, aclk, aresetn, 1'b1, $onehot0({chain_vld, pend_valid_reg}))
    `HDSU_ASSERT_SAME(a_pend_busy, aclk, aresetn, pend_valid_reg || (|chain_vld), busy_reg)
    `HDSU_ASSERT_SAME(a_out_from_pend, aclk, aresetn, $rose(m_tvalid_reg), $past(pend_valid_reg))

endmodule

// File: sim/tb_hamming_disparity_search_unit.sv
// testbench for hamming_disparity_search_unit: directed pixels, then random rows
// under several register settings and stall patterns, checked against a local predictor
// depends on hdsu_pkg and the hamming_disparity_search_unit rtl
`timescale 1ns / 1ps

module tb_hamming_disparity_search_unit;
    import hdsu_pkg::*;

    localparam int HIST_DEPTH = 64;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = HIST_DEPTH + 8;

    typedef struct packed {
        bit              first_in_row;
        bit [DESC_W-1:0] left_desc;
        bit [DESC_W-1:0] left_mask;
        bit              left_edge_area;
        bit [DESC_W-1:0] right_desc;
    } pixel_t;

    class disparity_scoreboard;
        bit [DESC_W-1:0] right_hist [HIST_DEPTH];
        int unsigned hist_fill;
        int unsigned levels_reg;
        int unsigned scale_reg;
        int unsigned errors;
        bit [OUT_W-1:0] disp_expected [$];

        function new();
            hist_fill = 0;
            levels_reg = 64;
            scale_reg = 1;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_LEVELS: levels_reg = data[LEV_W-1:0];
                REG_SCALE: scale_reg = data;
                default: ;
            endcase
        endfunction

        function void note_request(pixel_t px);
            bit [DESC_W-1:0] diff_bits;
            int unsigned span;
            int unsigned used;
            int unsigned best_dist;
            int unsigned best_disp;
            int unsigned hamm_dist;
            if (px.first_in_row) begin
                hist_fill = 0;
            end
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                right_hist[i] = right_hist[i-1];
            end
            right_hist[0] = px.right_desc;
            if (hist_fill < HIST_DEPTH) begin
                hist_fill++;
            end
            span = (levels_reg < HIST_DEPTH) ? levels_reg : HIST_DEPTH;
            if (hist_fill < span) begin
                span = hist_fill;
            end
            used = px.left_edge_area ? $countones(px.left_mask) : DESC_W;
            best_dist = DESC_W;
            best_disp = 0;
            // weak mask: too few used tests to trust any candidate
            if (used > DESC_W / 16) begin
                for (int d = 0; d < span; d++) begin
                    diff_bits = px.left_desc ^ right_hist[d];
                    if (px.left_edge_area) begin
                        diff_bits = diff_bits & px.left_mask;
                    end
                    hamm_dist = $countones(diff_bits);
                    if (hamm_dist < best_dist) begin
                        best_dist = hamm_dist;
                        best_disp = d;
                    end
                end
            end
            disp_expected.push_back(OUT_W'(best_disp * scale_reg));
        endfunction

        function int unsigned outstanding();
            return disp_expected.size();
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [OUT_W-1:0] got);
            bit [OUT_W-1:0] want;
            if (disp_expected.size() == 0) begin
                report_mismatch($sformatf("disparity_out %0d with no request pending", got));
                return;
            end
            want = disp_expected.pop_front();
            if (got !== want) begin
                report_mismatch($sformatf("disparity_out got %0d, expected %0d", got, want));
            end
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [191:0]         s_tdata = '0;
    logic [1:0]           s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LEVELS;
    logic [CFG_DAT_W-1:0] cfg_wdata = '0;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned rx_hold_req = 0;
    int unsigned rx_hold_seen = 0;
    int unsigned rx_hold_left = 0;
    int unsigned stall_cycles = 0;

    disparity_scoreboard sb = new();

    hamming_disparity_search_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // result side: check, then pick next ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
        if (rx_hold_seen != rx_hold_req) begin
            rx_hold_seen <= rx_hold_req;
            rx_hold_left <= RX_HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    function automatic bit [DESC_W-1:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic pixel_t make_pixel(bit first, bit [DESC_W-1:0] left,
                                          bit [DESC_W-1:0] mask, bit edge_area,
                                          bit [DESC_W-1:0] right);
        pixel_t px;
        px.first_in_row = first;
        px.left_desc = left;
        px.left_mask = mask;
        px.left_edge_area = edge_area;
        px.right_desc = right;
        return px;
    endfunction

    task automatic send_pixel(input pixel_t px);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {px.right_desc, px.left_mask, px.left_desc};
        s_tuser <= {px.left_edge_area, px.first_in_row};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(px);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic program_registers(input logic [CFG_DAT_W-1:0] lev,
                                     input logic [CFG_DAT_W-1:0] scl, input bit poke_spare);
        logic [CFG_DAT_W-1:0] junk;
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LEVELS;
        cfg_wdata <= lev;
        @(posedge aclk);
        sb.set_register(REG_LEVELS, lev);
        cfg_index <= REG_SCALE;
        cfg_wdata <= scl;
        @(posedge aclk);
        sb.set_register(REG_SCALE, scl);
        if (poke_spare) begin
            // out-of-range indexes must leave both registers alone
            junk = CFG_DAT_W'($urandom());
            cfg_index <= REG_SPARE_A;
            cfg_wdata <= junk;
            @(posedge aclk);
            sb.set_register(REG_SPARE_A, junk);
            junk = ~junk;
            cfg_index <= REG_SPARE_B;
            cfg_wdata <= junk;
            @(posedge aclk);
            sb.set_register(REG_SPARE_B, junk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // rows of random length; most left descriptors are noisy copies of a recent right one
    task automatic send_rows(input int count);
        bit [DESC_W-1:0] row_rights [$];
        pixel_t px;
        int row_left;
        int k;
        row_left = 0;
        for (int n = 0; n < count; n++) begin
            px.first_in_row = 1'b0;
            if (row_left == 0) begin
                row_left = ($urandom_range(99) < 15) ? $urandom_range(60, 90)
                                                     : $urandom_range(1, 24);
                px.first_in_row = ($urandom_range(99) < 95);
                if (px.first_in_row) begin
                    row_rights.delete();
                end
            end
            row_left--;
            if (row_rights.size() != 0 && $urandom_range(99) < 10) begin
                px.right_desc = row_rights[0];
            end else begin
                px.right_desc = rand64();
            end
            row_rights.push_front(px.right_desc);
            if (row_rights.size() > HIST_DEPTH + 8) begin
                void'(row_rights.pop_back());
            end
            if ($urandom_range(99) < 75) begin
                px.left_desc = row_rights[$urandom_range(row_rights.size() - 1)];
                repeat ($urandom_range(0, 8)) begin
                    k = $urandom_range(DESC_W - 1);
                    px.left_desc[k] = ~px.left_desc[k];
                end
            end else begin
                px.left_desc = rand64();
            end
            px.left_edge_area = ($urandom_range(99) < 35);
            case ($urandom_range(3))
                0: px.left_mask = '1;
                1: px.left_mask = rand64();
                2: begin
                    px.left_mask = '0;
                    repeat ($urandom_range(0, 6)) begin
                        px.left_mask[$urandom_range(DESC_W - 1)] = 1'b1;
                    end
                end
                default: px.left_mask = rand64() & rand64();
            endcase
            send_pixel(px);
        end
    endtask

    task automatic run_phase(input logic [CFG_DAT_W-1:0] lev, input logic [CFG_DAT_W-1:0] scl,
                             input int unsigned tx_pct, input int unsigned rx_pct,
                             input bit poke_spare, input int count);
        wait_drained();
        program_registers(lev, scl, poke_spare);
        tx_idle_pct = tx_pct;
        rx_idle_pct <= rx_pct;
        send_rows(count);
    endtask

    initial begin
        bit [DESC_W-1:0] a;
        bit [DESC_W-1:0] b;
        bit [DESC_W-1:0] c;
        bit [DESC_W-1:0] ones;
        ones = '1;
        a = rand64();
        b = rand64();
        c = rand64();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle_pct = 23;
        rx_idle_pct <= 78;
        @(posedge aclk);

        // reset settings; first row has no start mark
        send_pixel(make_pixel(1'b0, '0, '0, 1'b0, '0));
        send_pixel(make_pixel(1'b0, ones, ones, 1'b0, ones));
        send_pixel(make_pixel(1'b0, '0, ones, 1'b0, ones));
        // every candidate of the row's first pixel differs in all bits
        send_pixel(make_pixel(1'b1, ~a, ones, 1'b0, a));
        send_pixel(make_pixel(1'b0, a, ones, 1'b0, b));
        // weak masks on edge pixels, with one just above the limit among them
        send_pixel(make_pixel(1'b0, a, 64'hf, 1'b1, c));
        send_pixel(make_pixel(1'b0, a, 64'h1f, 1'b1, b));
        send_pixel(make_pixel(1'b0, a, '0, 1'b1, c));
        send_pixel(make_pixel(1'b0, a, ones, 1'b1, ~a));
        send_pixel(make_pixel(1'b0, a ^ 64'h1, ones, 1'b0, b));
        // tie between two equal candidates
        send_pixel(make_pixel(1'b1, b, ones, 1'b0, b));
        send_pixel(make_pixel(1'b0, b, ones, 1'b0, b));
        send_pixel(make_pixel(1'b0, b ^ 64'h8000_0000_0000_0000, ones, 1'b1, a));
        send_pixel(make_pixel(1'b0, ~b, ones, 1'b0, ~b));
        send_pixel(make_pixel(1'b0, ones, '0, 1'b0, c));
        send_pixel(make_pixel(1'b1, '0, ones, 1'b1, ones));

        run_phase(8'hc0, 8'd1, 23, 78, 1'b1, 150);
        run_phase(8'hff, 8'd255, 23, 78, 1'b0, 100);
        run_phase(8'd1, 8'd3, 78, 23, 1'b1, 100);
        run_phase(8'd0, 8'd200, 78, 23, 1'b0, 60);
        run_phase(CFG_DAT_W'($urandom_range(2, 63)), CFG_DAT_W'($urandom_range(255)),
                  78, 23, 1'b0, 100);
        run_phase(8'd64, 8'd0, 0, 0, 1'b0, 40);

        // long receiver hold-off with the sender still pushing
        wait_drained();
        program_registers(CFG_DAT_W'($urandom_range(8, 64)), CFG_DAT_W'($urandom_range(1, 255)),
                          1'b1);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        rx_hold_req <= rx_hold_req + 1;
        send_rows(90);
        wait_drained();
        send_rows(90);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
